// ----- hdl/joypad_and_keyboard_io_port_macros.svh -----
// ----------------------------------------------------------------------------
// Joypad and keyboard I/O port assertion macros
// Shared concurrent assertion forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef JOYPAD_AND_KEYBOARD_IO_PORT_MACROS_SVH
`define JOYPAD_AND_KEYBOARD_IO_PORT_MACROS_SVH

// checked only outside reset
`define JKIO_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define JKIO_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hdl/jkio_pkg.sv -----
// ----------------------------------------------------------------------------
// Joypad and keyboard I/O port package
// Word types and fixed codes of the port pair.
// ----------------------------------------------------------------------------
package jkio_pkg;

  localparam logic OP_WRITE  = 1'b1;
  localparam logic PORT_PAD1 = 1'b0;

  localparam logic [2:0] CMD_ROW_STEP    = 3'd4;
  localparam logic [2:0] CMD_ROW_CLEAR   = 3'd5;
  localparam logic [2:0] CMD_HALF_TOGGLE = 3'd6;

  localparam int unsigned NUM_ROWS = 9;
  localparam int unsigned KEY_BITS = 4;
  localparam int unsigned KEYS_W   = NUM_ROWS * KEY_BITS;

  localparam logic [7:0] PAD_RELEASED = 8'hff;
  localparam logic [7:0] PAD2_MASK    = 8'hf3;
  localparam logic [3:0] ROW_LAST     = 4'd9;

  typedef struct packed {
    logic              operation;
    logic              port_select;
    logic [7:0]        write_data;
    logic [7:0]        pad1_pressed;
    logic [7:0]        pad2_pressed;
    logic [KEYS_W-1:0] keys_half_one;
    logic [KEYS_W-1:0] keys_half_zero;
    logic              tape_in;
    logic              mic_in;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       tape_out;
  } out_item_t;

endpackage

// ----- hdl/joypad_and_keyboard_io_port.sv -----
// ----------------------------------------------------------------------------
// Joypad and keyboard I/O port
// Strobe/pad 1 port and pad 2/keyboard matrix port of an 8-bit console.
// ----------------------------------------------------------------------------
// Usage:
//   in channel  : one bus access word per handshake (operation, port, data,
//                 pad and keyboard levels, tape and mic inputs).
//   out channel : one result word per access (read byte, tape level).
//   An access is captured in an input register, handled by the port core
//   combinationally and placed in an output register. Throughput is one
//   access per cycle while the receiver does not stall; the port core
//   updates its state in the cycle the access moves into the output register.
//   When the receiver stalls, the output word holds, the input register
//   keeps one more access, and then in_ready_o drops until out moves.
//   Reset empties both registers, disarms the strobe, fills both pad
//   shift registers with ones, selects row zero, half zero, tape low.
// ----------------------------------------------------------------------------
module joypad_and_keyboard_io_port (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  jkio_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output jkio_pkg::out_item_t out_item_o
);

  logic                s1_valid_q;
  jkio_pkg::in_item_t  s1_item_q;
  logic                out_valid_q;
  jkio_pkg::out_item_t out_item_q;
  jkio_pkg::out_item_t result;
  logic                advance;

  assign advance    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || advance;

  jkio_port_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .item_i   (s1_item_q),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_item_q <= in_item_i;
    end
    if (advance) begin
      out_item_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

// ----- hdl/jkio_port_core.sv -----
// ----------------------------------------------------------------------------
// Joypad and keyboard port core
// Port state registers and the per-access read and update logic.
// ----------------------------------------------------------------------------
module jkio_port_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  jkio_pkg::in_item_t  item_i,
  output jkio_pkg::out_item_t result_o
);

  logic       armed_q, armed_d;
  logic [7:0] pad1_q, pad1_d;
  logic [7:0] pad2_q, pad2_d;
  logic [3:0] row_q, row_d;
  logic       half_q, half_d;
  logic       tape_q, tape_d;

  logic [7:0]                  rd;
  logic [jkio_pkg::KEYS_W-1:0] keys;
  logic [3:0]                  nib;

  always_comb begin
    keys = half_q ? item_i.keys_half_one : item_i.keys_half_zero;
    nib  = '0;
    for (int r = 0; r < jkio_pkg::NUM_ROWS; r++) begin
      if (row_q == 4'(r + 1)) begin
        nib = keys[r*jkio_pkg::KEY_BITS +: jkio_pkg::KEY_BITS];
      end
    end
  end

  always_comb begin
    armed_d = armed_q;
    pad1_d  = pad1_q;
    pad2_d  = pad2_q;
    row_d   = row_q;
    half_d  = half_q;
    tape_d  = tape_q;
    rd      = '0;
    if (item_i.operation == jkio_pkg::OP_WRITE) begin
      if (item_i.port_select == jkio_pkg::PORT_PAD1) begin
        if (item_i.write_data[0]) begin
          armed_d = 1'b1;
        end else if (armed_q) begin
          armed_d = 1'b0;
          pad1_d  = ~item_i.pad1_pressed;
          pad2_d  = ~(item_i.pad2_pressed & jkio_pkg::PAD2_MASK);
        end
        unique case (item_i.write_data[2:0])
          jkio_pkg::CMD_ROW_STEP: begin
            row_d  = (row_q >= jkio_pkg::ROW_LAST) ? 4'd0 : row_q + 4'd1;
            half_d = ~half_q;
          end
          jkio_pkg::CMD_ROW_CLEAR: begin
            row_d  = 4'd0;
            half_d = 1'b0;
          end
          jkio_pkg::CMD_HALF_TOGGLE: begin
            half_d = ~half_q;
          end
          default: ;
        endcase
        tape_d = item_i.write_data[1];
      end
    end else if (item_i.port_select == jkio_pkg::PORT_PAD1) begin
      rd     = {5'b0, item_i.mic_in, item_i.tape_in, pad1_q[0]};
      pad1_d = {1'b0, pad1_q[7:1]};
    end else begin
      rd     = {7'h7f, pad2_q[0]} & ~{3'b0, nib, 1'b0};
      pad2_d = {1'b0, pad2_q[7:1]};
    end
  end

  assign result_o.read_data = rd;
  assign result_o.tape_out  = tape_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q <= 1'b0;
      pad1_q  <= jkio_pkg::PAD_RELEASED;
      pad2_q  <= jkio_pkg::PAD_RELEASED;
      row_q   <= 4'd0;
      half_q  <= 1'b0;
      tape_q  <= 1'b0;
    end else if (step_i) begin
      armed_q <= armed_d;
      pad1_q  <= pad1_d;
      pad2_q  <= pad2_d;
      row_q   <= row_d;
      half_q  <= half_d;
      tape_q  <= tape_d;
    end
  end

endmodule

// ----- hdl/jkio_checker.sv -----
// ----------------------------------------------------------------------------
// Joypad and keyboard port checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`include "joypad_and_keyboard_io_port_macros.svh"

module jkio_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input jkio_pkg::in_item_t  in_item_i,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input jkio_pkg::out_item_t out_item_o
);

  logic in_take;
  logic in_wait;
  logic out_wait;

  assign in_take  = in_valid_i && in_ready_o;
  assign in_wait  = in_valid_i && !in_ready_o;
  assign out_wait = out_valid_o && !out_ready_i;

  `JKIO_ASSERT(a_out_hold, clk_i, rst_ni, out_wait |=> out_valid_o, "out word dropped")
  `JKIO_ASSERT(a_out_stable, clk_i, rst_ni, out_wait |=> $stable(out_item_o), "out word changed")
  `JKIO_ASSERT_ALWAYS(a_ready_empty, clk_i, !out_valid_o |-> in_ready_o, "stall, output empty")
  `JKIO_ASSERT(a_latency, clk_i, rst_ni, in_take ##1 !out_valid_o |=> out_valid_o, "word lost")
  `JKIO_ASSERT(a_in_stable, clk_i, rst_ni, in_wait |=> in_valid_i && $stable(in_item_i), "in moved")

endmodule

bind joypad_and_keyboard_io_port jkio_checker u_checker (.*);

// ----- bench/joypad_and_keyboard_io_port_tb.sv -----
// ----------------------------------------------------------------------------
// Joypad and keyboard I/O port testbench
// Sends bus access words through the valid/ready input channel. A behavioral
// copy of the port pair predicts each result word. Results are compared in
// order as they leave the block, with random gaps and output stalls.
// ----------------------------------------------------------------------------
module joypad_and_keyboard_io_port_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic OP_READ   = ~jkio_pkg::OP_WRITE;
  localparam logic PORT_KEYS = ~jkio_pkg::PORT_PAD1;

  localparam logic [2:0] CMD_NONE = 3'd0;

  localparam int unsigned CYCLE_LIMIT     = 250000;
  localparam int unsigned RANDOM_WORDS    = 1250;
  localparam int unsigned FULL_RATE_WORDS = 100;
  localparam int unsigned DRAIN_CYCLES    = 8;

  logic                clk_i     = 1'b0;
  logic                rst_ni    = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  jkio_pkg::in_item_t  in_item   = '0;
  logic                out_valid;
  logic                out_ready = 1'b1;
  jkio_pkg::out_item_t out_item;

  // predicted port state
  logic       armed;
  logic [7:0] pad1_sr;
  logic [7:0] pad2_sr;
  logic [3:0] row;
  logic       half;
  logic       tape;

  jkio_pkg::out_item_t port_results_q[$];
  jkio_pkg::out_item_t exp_word;

  bit idle_on  = 1'b0;
  bit stall_on = 1'b0;

  int unsigned n_sent;
  int unsigned n_checked;
  int unsigned n_errors;
  int unsigned n_latches;
  int unsigned n_key_reads;

  joypad_and_keyboard_io_port dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  function automatic jkio_pkg::out_item_t port_predict(jkio_pkg::in_item_t w);
    jkio_pkg::out_item_t r;
    logic [35:0]         keys;
    logic [3:0]          nib;
    r.read_data = '0;
    if (w.operation == jkio_pkg::OP_WRITE) begin
      if (w.port_select == jkio_pkg::PORT_PAD1) begin
        if (w.write_data[0]) begin
          armed = 1'b1;
        end else if (armed) begin
          armed   = 1'b0;
          pad1_sr = ~w.pad1_pressed;
          pad2_sr = ~(w.pad2_pressed & jkio_pkg::PAD2_MASK);
          n_latches++;
        end
        case (w.write_data[2:0])
          jkio_pkg::CMD_ROW_STEP: begin
            row  = (row >= jkio_pkg::ROW_LAST) ? 4'd0 : row + 4'd1;
            half = ~half;
          end
          jkio_pkg::CMD_ROW_CLEAR: begin
            row  = 4'd0;
            half = 1'b0;
          end
          jkio_pkg::CMD_HALF_TOGGLE: begin
            half = ~half;
          end
          default: begin
          end
        endcase
        tape = w.write_data[1];
      end
    end else if (w.port_select == jkio_pkg::PORT_PAD1) begin
      r.read_data = {5'd0, w.mic_in, w.tape_in, pad1_sr[0]};
      pad1_sr     = pad1_sr >> 1;
    end else begin
      r.read_data = {7'h7f, pad2_sr[0]};
      pad2_sr     = pad2_sr >> 1;
      if (row >= 4'd1 && row <= jkio_pkg::ROW_LAST) begin
        keys        = half ? w.keys_half_one : w.keys_half_zero;
        nib         = keys[4*(row-1) +: 4];
        r.read_data = r.read_data & ~{3'd0, nib, 1'b0};
        n_key_reads++;
      end
    end
    r.tape_out = tape;
    return r;
  endfunction

  function automatic jkio_pkg::in_item_t any_word();
    jkio_pkg::in_item_t w;
    logic [63:0]        rnd;
    w.operation      = 1'($urandom_range(0, 1));
    w.port_select    = 1'($urandom_range(0, 1));
    w.write_data     = 8'($urandom);
    w.pad1_pressed   = 8'($urandom);
    w.pad2_pressed   = 8'($urandom);
    rnd              = {$urandom, $urandom};
    w.keys_half_one  = rnd[jkio_pkg::KEYS_W-1:0];
    rnd              = {$urandom, $urandom};
    w.keys_half_zero = rnd[jkio_pkg::KEYS_W-1:0];
    w.tape_in        = 1'($urandom_range(0, 1));
    w.mic_in         = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 7))
      0: w.keys_half_one  = '1;
      1: w.keys_half_zero = '1;
      2: w.keys_half_one  = '0;
      default: begin
      end
    endcase
    return w;
  endfunction

  // call at a rising edge; returns at the edge where the word is taken, or after a random idle gap behind it
  task automatic send_word(jkio_pkg::in_item_t w);
    in_valid <= 1'b1;
    in_item  <= w;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    port_results_q.push_back(port_predict(w));
    n_sent++;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
  endtask

  initial begin
    forever begin
      @(posedge clk_i);
      if (stall_on && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk_i);
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid && out_ready) begin
      if (port_results_q.size() == 0) begin
        $display("%0t: unexpected result word read_data %02h tape_out %0b",
                 $time, out_item.read_data, out_item.tape_out);
        n_errors++;
      end else begin
        exp_word = port_results_q.pop_front();
        n_checked++;
        if (out_item.read_data !== exp_word.read_data) begin
          $display("%0t: read_data expected %02h actual %02h",
                   $time, exp_word.read_data, out_item.read_data);
          n_errors++;
        end
        if (out_item.tape_out !== exp_word.tape_out) begin
          $display("%0t: tape_out expected %0b actual %0b",
                   $time, exp_word.tape_out, out_item.tape_out);
          n_errors++;
        end
      end
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("%0t: timeout, %0d words still expected", $time, port_results_q.size());
    $display("joypad_and_keyboard_io_port_tb: errors");
    $finish;
  end

  task automatic test_reset_reads();
    jkio_pkg::in_item_t w;
    w             = '0;
    w.operation   = OP_READ;
    w.port_select = jkio_pkg::PORT_PAD1;
    w.tape_in     = 1'b1;
    w.mic_in      = 1'b1;
    send_word(w);
    // row zero: keys never pull lines low
    w.port_select    = PORT_KEYS;
    w.keys_half_one  = '1;
    w.keys_half_zero = '1;
    send_word(w);
  endtask

  task automatic test_port1_write();
    jkio_pkg::in_item_t w;
    w             = '1;
    w.operation   = jkio_pkg::OP_WRITE;
    w.port_select = PORT_KEYS;
    send_word(w);
    w             = '0;
    w.operation   = OP_READ;
    w.port_select = jkio_pkg::PORT_PAD1;
    send_word(w);
    w.port_select = PORT_KEYS;
    send_word(w);
  endtask

  task automatic test_strobe_latch();
    jkio_pkg::in_item_t w;
    // clear write while disarmed must not latch
    w              = '0;
    w.operation    = jkio_pkg::OP_WRITE;
    w.port_select  = jkio_pkg::PORT_PAD1;
    w.pad1_pressed = 8'hff;
    w.pad2_pressed = 8'hff;
    send_word(w);
    w.write_data = 8'h01;
    send_word(w);
    w.write_data = 8'h00;
    send_word(w);
    w.operation = OP_READ;
    repeat (3) begin
      w.port_select = jkio_pkg::PORT_PAD1;
      send_word(w);
      w.port_select = PORT_KEYS;
      send_word(w);
    end
    w.operation    = jkio_pkg::OP_WRITE;
    w.port_select  = jkio_pkg::PORT_PAD1;
    w.write_data   = 8'h03;
    send_word(w);
    w.write_data   = 8'h02;
    w.pad1_pressed = 8'h00;
    w.pad2_pressed = 8'h00;
    send_word(w);
    w.operation = OP_READ;
    send_word(w);
    w.port_select = PORT_KEYS;
    send_word(w);
  endtask

  task automatic test_keyboard_scan();
    jkio_pkg::in_item_t w;
    w                = '0;
    w.keys_half_one  = '1;
    w.operation      = jkio_pkg::OP_WRITE;
    w.port_select    = jkio_pkg::PORT_PAD1;
    w.write_data     = {5'd0, jkio_pkg::CMD_ROW_CLEAR};
    send_word(w);
    w.write_data = {5'd0, jkio_pkg::CMD_ROW_STEP};
    send_word(w);
    w.operation   = OP_READ;
    w.port_select = PORT_KEYS;
    send_word(w);
    w.operation   = jkio_pkg::OP_WRITE;
    w.port_select = jkio_pkg::PORT_PAD1;
    w.write_data  = {5'd0, jkio_pkg::CMD_HALF_TOGGLE};
    send_word(w);
    w.operation   = OP_READ;
    w.port_select = PORT_KEYS;
    send_word(w);
    w.operation   = jkio_pkg::OP_WRITE;
    w.port_select = jkio_pkg::PORT_PAD1;
    w.write_data  = 8'hff;
    send_word(w);
  endtask

  task automatic test_random_traffic();
    jkio_pkg::in_item_t w;
    while (n_sent < RANDOM_WORDS) begin
      idle_on  = ($urandom_range(0, 3) != 0);
      stall_on = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 4))
        0, 1: begin
          w               = any_word();
          w.operation     = jkio_pkg::OP_WRITE;
          w.port_select   = jkio_pkg::PORT_PAD1;
          w.write_data[0] = 1'b1;
          send_word(w);
          w               = any_word();
          w.operation     = jkio_pkg::OP_WRITE;
          w.port_select   = jkio_pkg::PORT_PAD1;
          w.write_data[0] = 1'b0;
          send_word(w);
          repeat ($urandom_range(1, 10)) begin
            w           = any_word();
            w.operation = OP_READ;
            send_word(w);
          end
        end
        2, 3: begin
          w                 = any_word();
          w.operation       = jkio_pkg::OP_WRITE;
          w.port_select     = jkio_pkg::PORT_PAD1;
          w.write_data[2:0] = jkio_pkg::CMD_ROW_CLEAR;
          send_word(w);
          repeat ($urandom_range(1, 12)) begin
            w                 = any_word();
            w.operation       = jkio_pkg::OP_WRITE;
            w.port_select     = jkio_pkg::PORT_PAD1;
            w.write_data[2:0] = ($urandom_range(0, 4) == 0)
                                ? jkio_pkg::CMD_HALF_TOGGLE
                                : jkio_pkg::CMD_ROW_STEP;
            send_word(w);
            repeat ($urandom_range(1, 2)) begin
              w             = any_word();
              w.operation   = OP_READ;
              w.port_select = PORT_KEYS;
              send_word(w);
            end
          end
        end
        default: begin
          repeat ($urandom_range(1, 6)) send_word(any_word());
        end
      endcase
    end
  endtask

  task automatic test_full_rate();
    jkio_pkg::in_item_t w;
    idle_on  = 1'b0;
    stall_on = 1'b0;
    repeat (FULL_RATE_WORDS) begin
      w = any_word();
      if ($urandom_range(0, 1) == 0) begin
        w.write_data[2:0] = CMD_NONE;
      end
      send_word(w);
    end
  endtask

  initial begin
    armed   = 1'b0;
    pad1_sr = jkio_pkg::PAD_RELEASED;
    pad2_sr = jkio_pkg::PAD_RELEASED;
    row     = 4'd0;
    half    = 1'b0;
    tape    = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_reads();
    test_port1_write();
    test_strobe_latch();
    test_keyboard_scan();
    test_random_traffic();
    test_full_rate();

    if (in_valid) in_valid <= 1'b0;
    while (port_results_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("%0d accesses sent, %0d result words checked", n_sent, n_checked);
    $display("%0d pad latches, %0d keyboard row reads", n_latches, n_key_reads);
    if (n_errors == 0) begin
      $display("joypad_and_keyboard_io_port_tb: clean");
    end else begin
      $display("joypad_and_keyboard_io_port_tb: errors");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/jkio_pkg.sv
hdl/jkio_port_core.sv
hdl/joypad_and_keyboard_io_port.sv
hdl/jkio_checker.sv
bench/joypad_and_keyboard_io_port_tb.sv
